// ===== hdl/msc_pkg.sv =====
// Shared constants, types and helpers for the magnetometer sample conditioner.
package msc_pkg;

    localparam int MAX_STEPS_DEF       = 10;
    localparam int SCALE_FRAC_BITS_DEF = 14;

    localparam int RAW_W   = 16;
    localparam int OUT_W   = 19;
    localparam int OFF_W   = 17;
    localparam int SCALE_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int TOT_W   = 23;
    localparam int QUEUE_DEPTH = 2;
    localparam int SCALE_RESET = 16384;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 19'sd262143;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -19'sd262144;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AXIS_MAP    = 3'd0,
        REG_SMOOTH_CTRL = 3'd1,
        REG_OFFSET_X    = 3'd2,
        REG_OFFSET_Y    = 3'd3,
        REG_OFFSET_Z    = 3'd4,
        REG_SCALE_X     = 3'd5,
        REG_SCALE_Y     = 3'd6,
        REG_SCALE_Z     = 3'd7
    } reg_index_t;

    // One calibrated vector travelling from the front end to the back end.
    typedef struct packed {
        logic signed [OUT_W-1:0] cal_x;
        logic signed [OUT_W-1:0] cal_y;
        logic signed [OUT_W-1:0] cal_z;
    } cal_vec_t;

    // Smoothing controls decoded from smooth_ctrl.
    typedef struct packed {
        logic       enable;
        logic       trimmed;
        logic [3:0] steps;
    } smooth_cfg_t;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [47:0] v);
        logic signed [OUT_W-1:0] r;
        begin
            if (v > 48'(OUT_MAX))
                r = OUT_MAX;
            else if (v < 48'(OUT_MIN))
                r = OUT_MIN;
            else
                r = v[OUT_W-1:0];
            return r;
        end
    endfunction

endpackage

// ===== hdl/msc_front.sv =====
// Front end: axis remap, hard-iron offset, soft-iron scale, one axis per cycle.
module msc_front
    import msc_pkg::*;
#(
    parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [RAW_W-1:0]   raw_x,
    input  logic signed [RAW_W-1:0]   raw_y,
    input  logic signed [RAW_W-1:0]   raw_z,
    input  logic [8:0]                axis_map,
    input  logic signed [OFF_W-1:0]   offset [3],
    input  logic [SCALE_W-1:0]        scale [3],
    output logic                      q_valid,
    input  logic                      q_ready,
    output cal_vec_t                  q_data
);

    typedef enum logic [1:0] { ST_IDLE, ST_MUL, ST_PUSH } state_t;

    state_t                  state_reg;
    logic [1:0]              axis_reg;
    logic signed [RAW_W-1:0] raw_reg [3];
    logic signed [OUT_W-1:0] cal_reg [3];
    logic signed [47:0]      prod_reg;
    logic                    prod_ok_reg;

    logic [1:0]              src;
    logic signed [RAW_W+1:0] m;
    logic signed [RAW_W+2:0] diff;
    logic signed [47:0]      prod;
    logic signed [47:0]      quot;
    logic [1:0]              paxis;

    assign in_ready = (state_reg == ST_IDLE);
    assign q_valid  = (state_reg == ST_PUSH);
    assign q_data   = '{cal_x: cal_reg[0], cal_y: cal_reg[1], cal_z: cal_reg[2]};

    always_comb
    begin
        src = axis_map[2*axis_reg +: 2];
        m   = (src == 2'd3) ? '0 : (RAW_W+2)'(raw_reg[src]);
        if (axis_map[6 + axis_reg])
            m = -m;
        diff = ((RAW_W+3)'(m) <<< 1) - (RAW_W+3)'(offset[axis_reg]);
        prod = 48'(diff) * $signed({1'b0, scale[axis_reg]});
        // truncate toward zero
        quot = (prod_reg < 0) ? -((-prod_reg) >>> (SCALE_FRAC_BITS + 1))
                              : (prod_reg >>> (SCALE_FRAC_BITS + 1));
        paxis = axis_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            axis_reg    <= '0;
            prod_ok_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        raw_reg[0]  <= raw_x;
                        raw_reg[1]  <= raw_y;
                        raw_reg[2]  <= raw_z;
                        axis_reg    <= '0;
                        prod_ok_reg <= 1'b0;
                        state_reg   <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    if (prod_ok_reg)
                        cal_reg[paxis] <= sat_out(quot);
                    if (axis_reg == 2'd3)
                    begin
                        state_reg <= ST_PUSH;
                    end
                    else
                    begin
                        prod_reg    <= prod;
                        prod_ok_reg <= 1'b1;
                    end
                    axis_reg <= axis_reg + 2'd1;
                end
                ST_PUSH:
                begin
                    if (q_ready)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/msc_queue.sv =====
// Short FIFO between the front and back ends.
module msc_queue
    import msc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_valid,
    output logic     wr_ready,
    input  cal_vec_t wr_data,
    output logic     rd_valid,
    input  logic     rd_ready,
    output cal_vec_t rd_data
);

    cal_vec_t   mem_reg [QUEUE_DEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_ready = (cnt_reg != 2'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign push = wr_valid && wr_ready;
    assign pop  = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                mem_reg[wp_reg] <= wr_data;
                wp_reg <= ~wp_reg;
            end
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== hdl/msc_back.sv =====
// Back end: smoothing ring, running totals, plain or trimmed mean and serial divider.
module msc_back
    import msc_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    output logic                    q_ready,
    input  cal_vec_t                q_data,
    input  smooth_cfg_t             scfg,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [OUT_W-1:0] field_x,
    output logic signed [OUT_W-1:0] field_y,
    output logic signed [OUT_W-1:0] field_z
);

    localparam int IW = $clog2(MAX_STEPS);
    localparam int DW = TOT_W + 1;

    typedef enum logic [2:0] { ST_IDLE, ST_UPD, ST_SCAN, ST_DIV, ST_OUT } state_t;

    state_t                  state_reg;
    logic signed [OUT_W-1:0] ring_reg [MAX_STEPS][3];
    logic signed [TOT_W-1:0] tot_reg [3];
    logic [3:0]              slot_reg;
    logic signed [OUT_W-1:0] cal_reg [3];
    logic signed [OUT_W-1:0] res_reg [3];
    logic [1:0]              axis_reg;
    logic [3:0]              j_reg;
    logic signed [OUT_W-1:0] hi_reg, lo_reg;
    logic [DW-1:0]           rem_reg, quo_reg;
    logic [4:0]              bit_reg;
    logic                    neg_reg;
    logic [3:0]              div_reg;

    logic [3:0]              steps;
    logic                    trim;
    logic [IW-1:0]           slot_idx, j_idx;
    logic signed [OUT_W-1:0] ent;
    logic signed [TOT_W+1:0] sum;
    logic [DW-1:0]           rem_sh;
    logic signed [47:0]      qs;

    always_comb
    begin
        steps = scfg.steps;
        if (steps < 4'd2)
            steps = 4'd2;
        if (32'(steps) > MAX_STEPS)
            steps = 4'(MAX_STEPS);
        trim     = scfg.trimmed && (steps >= 4'd3);
        slot_idx = slot_reg[IW-1:0];
        j_idx    = j_reg[IW-1:0];
        ent      = ring_reg[j_idx][axis_reg];
        sum      = (TOT_W+2)'(tot_reg[axis_reg]) - (TOT_W+2)'(hi_reg) - (TOT_W+2)'(lo_reg);
        rem_sh   = {rem_reg[DW-2:0], quo_reg[DW-1]};
        qs       = neg_reg ? -48'(quo_reg) : 48'(quo_reg);
    end

    assign q_ready   = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign field_x   = res_reg[0];
    assign field_y   = res_reg[1];
    assign field_z   = res_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
            for (int i = 0; i < MAX_STEPS; i++)
                for (int a = 0; a < 3; a++)
                    ring_reg[i][a] <= '0;
            for (int a = 0; a < 3; a++)
                tot_reg[a] <= '0;
            axis_reg <= '0;
            j_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        cal_reg[0] <= q_data.cal_x;
                        cal_reg[1] <= q_data.cal_y;
                        cal_reg[2] <= q_data.cal_z;
                        res_reg[0] <= q_data.cal_x;
                        res_reg[1] <= q_data.cal_y;
                        res_reg[2] <= q_data.cal_z;
                        if (scfg.enable)
                        begin
                            if (slot_reg > steps - 4'd1)
                                slot_reg <= '0;
                            state_reg <= ST_UPD;
                        end
                        else
                            state_reg <= ST_OUT;
                    end
                end
                ST_UPD:
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        ring_reg[slot_idx][a] <= cal_reg[a];
                        tot_reg[a] <= tot_reg[a] - TOT_W'(ring_reg[slot_idx][a])
                                      + TOT_W'(cal_reg[a]);
                    end
                    slot_reg <= slot_reg + 4'd1;
                    axis_reg <= '0;
                    j_reg    <= '0;
                    hi_reg   <= '0;
                    lo_reg   <= '0;
                    state_reg <= trim ? ST_SCAN : ST_DIV;
                    bit_reg   <= '1;
                end
                ST_SCAN:
                begin
                    if (j_reg == 4'd0)
                    begin
                        hi_reg <= ent;
                        lo_reg <= ent;
                    end
                    else
                    begin
                        if (ent > hi_reg)
                            hi_reg <= ent;
                        if (ent < lo_reg)
                            lo_reg <= ent;
                    end
                    if (j_reg == steps - 4'd1)
                    begin
                        bit_reg   <= '1;
                        state_reg <= ST_DIV;
                    end
                    j_reg <= j_reg + 4'd1;
                end
                ST_DIV:
                begin
                    if (bit_reg == '1)
                    begin
                        // load magnitude, restoring division one bit a cycle
                        neg_reg <= sum < 0;
                        quo_reg <= (sum < 0) ? DW'(-sum) : DW'(sum);
                        rem_reg <= '0;
                        div_reg <= trim ? steps - 4'd2 : steps;
                        bit_reg <= 5'(DW - 1);
                    end
                    else if (bit_reg == 5'd30)
                    begin
                        res_reg[axis_reg] <= sat_out(qs);
                        hi_reg <= '0;
                        lo_reg <= '0;
                        j_reg  <= '0;
                        bit_reg <= '1;
                        if (axis_reg == 2'd2)
                            state_reg <= ST_OUT;
                        else
                        begin
                            axis_reg  <= axis_reg + 2'd1;
                            state_reg <= trim ? ST_SCAN : ST_DIV;
                        end
                    end
                    else
                    begin
                        if (rem_sh >= DW'(div_reg))
                        begin
                            rem_reg <= rem_sh - DW'(div_reg);
                            quo_reg <= {quo_reg[DW-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[DW-2:0], 1'b0};
                        end
                        if (bit_reg == 5'd0)
                            bit_reg <= 5'd30;
                        else
                            bit_reg <= bit_reg - 5'd1;
                    end
                end
                ST_OUT:
                begin
                    if (out_ready)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/magnetometer_sample_conditioner_unit.sv =====
// Top level of the magnetometer sample conditioner.
// Usage:
//   Input channel in_valid/in_ready carries raw_x/y/z (chip axes). Output
//   channel out_valid/out_ready carries field_x/y/z (board axes). Registers
//   are written over cfg_valid/cfg_ready with cfg_index and cfg_data; the
//   user must write them only while the block is idle, which the block itself
//   does not enforce, and cfg_ready is always high.
//   The front end remaps, offsets and scales one axis per cycle on a shared
//   multiplier and takes a new input only after it has pushed the last one
//   to the queue. A two-entry queue decouples it from the back end, which
//   updates the ring, walks up to MAX_STEPS slots per axis for the trimmed
//   mean and runs a restoring divider one quotient bit per cycle. With
//   smoothing off the back end passes the calibrated vector straight to the
//   outputs; with smoothing on its time is set by the serial divider and,
//   for the trimmed mean, the min/max walk.
//   Reset restores register defaults and clears ring, totals and slot at
//   once. When the receiver stalls the result holds on the outputs; the
//   front end keeps accepting until the queue is full.
module magnetometer_sample_conditioner_unit
    import msc_pkg::*;
#(
    parameter int MAX_STEPS       = MAX_STEPS_DEF,
    parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [RAW_W-1:0] raw_x,
    input  logic signed [RAW_W-1:0] raw_y,
    input  logic signed [RAW_W-1:0] raw_z,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [OUT_W-1:0] field_x,
    output logic signed [OUT_W-1:0] field_y,
    output logic signed [OUT_W-1:0] field_z,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    logic [8:0]              axis_map_reg;
    logic [5:0]              smooth_reg;
    logic signed [OFF_W-1:0] offset_reg [3];
    logic [SCALE_W-1:0]      scale_reg [3];
    smooth_cfg_t             scfg;

    logic     fq_valid, fq_ready, bq_valid, bq_ready;
    cal_vec_t fq_data, bq_data;

    assign cfg_ready = 1'b1;
    assign scfg = '{enable: smooth_reg[0], trimmed: smooth_reg[1], steps: smooth_reg[5:2]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_map_reg <= 9'd36;
            smooth_reg   <= 6'd8;
            for (int a = 0; a < 3; a++)
            begin
                offset_reg[a] <= '0;
                scale_reg[a]  <= SCALE_W'(SCALE_RESET);
            end
        end
        else if (cfg_valid)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_AXIS_MAP:    axis_map_reg  <= cfg_data[8:0];
                REG_SMOOTH_CTRL: smooth_reg    <= cfg_data[5:0];
                REG_OFFSET_X:    offset_reg[0] <= cfg_data;
                REG_OFFSET_Y:    offset_reg[1] <= cfg_data;
                REG_OFFSET_Z:    offset_reg[2] <= cfg_data;
                REG_SCALE_X:     scale_reg[0]  <= cfg_data[15:0];
                REG_SCALE_Y:     scale_reg[1]  <= cfg_data[15:0];
                REG_SCALE_Z:     scale_reg[2]  <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    msc_front #(.SCALE_FRAC_BITS(SCALE_FRAC_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .raw_x(raw_x), .raw_y(raw_y), .raw_z(raw_z),
        .axis_map(axis_map_reg), .offset(offset_reg), .scale(scale_reg),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
    );

    msc_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
        .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_data)
    );

    msc_back #(.MAX_STEPS(MAX_STEPS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(bq_valid), .q_ready(bq_ready), .q_data(bq_data),
        .scfg(scfg),
        .out_valid(out_valid), .out_ready(out_ready),
        .field_x(field_x), .field_y(field_y), .field_z(field_z)
    );

endmodule
